// ===== rtl/core/rgba_over_alpha_blender_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the source-over blender
// Shared property forms; each use expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef RGBA_OVER_ALPHA_BLENDER_UNIT_ASSERT_SVH
`define RGBA_OVER_ALPHA_BLENDER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ROB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ROB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rob_pkg.sv =====
// ----------------------------------------------------------------------------
// rob_pkg
// Types, register indexes and divide-by-255 helpers for the blender.
// ----------------------------------------------------------------------------
package rob_pkg;

  localparam int unsigned ROB_QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W       = 4;
  localparam int unsigned DVD_W           = 17;

  localparam logic [CFG_IDX_W-1:0] REG_LAYER_OPACITY = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_MODE     = 4'd1;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;
  } rob_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } rob_out_t;

  typedef struct packed {
    logic [7:0] opacity;
    logic       gray;
  } rob_cfg_t;

  // A classified pixel: source colours already gray-expanded.
  typedef struct packed {
    rob_in_t    pix;
    logic [7:0] ea;
    logic       bypass;
  } rob_job_t;

  // Lower estimate of x / 255 from a multiply by 257; it is short by at most two.
  function automatic logic [15:0] d255_est(input logic [23:0] x);
    logic [32:0] p;
    p = {9'd0, x} * 33'd257;
    return p[31:16];
  endfunction

  // Corrects the estimate with one remainder and two compares.
  function automatic logic [15:0] d255_fix(input logic [23:0] x, input logic [15:0] q0);
    logic [23:0] prod;
    logic [23:0] r;
    prod = {q0, 8'd0} - {8'd0, q0};
    r    = x - prod;
    if (r >= 24'd510) begin
      return q0 + 16'd2;
    end else if (r >= 24'd255) begin
      return q0 + 16'd1;
    end else begin
      return q0;
    end
  endfunction

endpackage

// ===== rtl/core/rob_front.sv =====
// ----------------------------------------------------------------------------
// rob_front
// Takes input beats, applies gray mode and works out the effective alpha.
// ----------------------------------------------------------------------------
module rob_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rob_pkg::rob_in_t  in_data,
  input  rob_pkg::rob_cfg_t cfg,
  output logic              job_valid,
  input  logic              job_ready,
  output rob_pkg::rob_job_t job
);
  import rob_pkg::*;

  logic        fen;
  logic        f1_v_r, f2_v_r, f3_v_r;
  rob_in_t     pix_nxt;
  logic [15:0] prod_nxt;
  rob_in_t     f1_pix_r, f2_pix_r;
  logic [15:0] f1_prod_r;
  logic [23:0] x_nxt, f2_x_r;
  logic [15:0] f2_q0_r;
  logic [15:0] ea_full;
  rob_job_t    f3_job_r;

  assign fen      = !f3_v_r || job_ready;
  assign in_ready = fen;

  always_comb begin
    pix_nxt = in_data;
    if (cfg.gray) begin
      pix_nxt.src_green = in_data.src_red;
      pix_nxt.src_blue  = in_data.src_red;
    end
    prod_nxt = {8'd0, in_data.src_alpha} * {8'd0, cfg.opacity};
  end

  assign x_nxt   = {8'd0, f1_prod_r} + 24'd127;
  assign ea_full = d255_fix(f2_x_r, f2_q0_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (fen) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      f1_pix_r        <= pix_nxt;
      f1_prod_r       <= prod_nxt;
      f2_pix_r        <= f1_pix_r;
      f2_x_r          <= x_nxt;
      f2_q0_r         <= d255_est(x_nxt);
      f3_job_r.pix    <= f2_pix_r;
      f3_job_r.ea     <= ea_full[7:0];
      f3_job_r.bypass <= (ea_full[7:0] == 8'd0);
    end
  end

  assign job_valid = f3_v_r;
  assign job       = f3_job_r;

endmodule

// ===== rtl/core/rob_queue.sv =====
// ----------------------------------------------------------------------------
// rob_queue
// Small FIFO between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module rob_queue #(
  parameter int unsigned DEPTH = rob_pkg::ROB_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  rob_pkg::rob_job_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output rob_pkg::rob_job_t pop_data
);
  import rob_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rob_job_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PTR_LAST) ? '0 : wr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == PTR_LAST) ? '0 : rd_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/rob_back.sv =====
// ----------------------------------------------------------------------------
// rob_back
// Compositing arithmetic: premultiplied sums, then a pipelined divide by oa.
// ----------------------------------------------------------------------------
module rob_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  rob_pkg::rob_job_t job,
  output logic              out_valid,
  input  logic              out_ready,
  output rob_pkg::rob_out_t out_data
);
  import rob_pkg::*;

  `include "rgba_over_alpha_blender_unit_assert.svh"

  typedef struct packed {
    logic       bypass;
    logic [7:0] oa;
    logic [7:0] dr;
    logic [7:0] dg;
    logic [7:0] db;
    logic [7:0] da;
  } rob_side_t;

  logic ben;
  logic out_valid_r;
  assign ben       = !out_valid_r || out_ready;
  assign job_ready = ben;

  logic [7:0] src_c [3];
  logic [7:0] dst_c [3];
  always_comb begin
    src_c[0] = job.pix.src_red;
    src_c[1] = job.pix.src_green;
    src_c[2] = job.pix.src_blue;
    dst_c[0] = job.pix.dst_red;
    dst_c[1] = job.pix.dst_green;
    dst_c[2] = job.pix.dst_blue;
  end

  // Stage 1 products
  logic        b1_v_r, b2_v_r, b3_v_r, b4_v_r, b5_v_r;
  rob_in_t     b1_pix_r, b2_pix_r, b3_pix_r, b4_pix_r, b5_pix_r;
  logic        b1_byp_r, b2_byp_r, b3_byp_r, b4_byp_r, b5_byp_r;
  logic [7:0]  b1_ea_r, b2_ea_r, b3_ea_r;
  logic [7:0]  b1_ia_r;
  logic [15:0] b1_ma_r;
  logic [15:0] b1_mc_r [3];
  logic [15:0] b1_sc_r [3], b2_sc_r [3], b3_sc_r [3];
  logic [23:0] xa_nxt, b2_xa_r;
  logic [15:0] b2_qa0_r;
  logic [23:0] b2_mc2_r [3];
  logic [15:0] term_full;
  logic [7:0]  b3_term_r;
  logic [23:0] xc_nxt [3];
  logic [23:0] b3_xc_r [3];
  logic [15:0] b3_qc0_r [3];
  logic [15:0] qc_full [3];
  logic [16:0] b4_cp_r [3];
  logic [7:0]  b4_oa_r, b5_oa_r;
  logic [DVD_W-1:0] b5_dvd_r [3];

  assign xa_nxt    = {8'd0, b1_ma_r} + 24'd127;
  assign term_full = d255_fix(b2_xa_r, b2_qa0_r);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      xc_nxt[c]  = b2_mc2_r[c] + 24'd127;
      qc_full[c] = d255_fix(b3_xc_r[c], b3_qc0_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      b4_v_r <= 1'b0;
      b5_v_r <= 1'b0;
    end else if (ben) begin
      b1_v_r <= job_valid;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
      b4_v_r <= b3_v_r;
      b5_v_r <= b4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      b1_pix_r <= job.pix;
      b1_byp_r <= job.bypass;
      b1_ea_r  <= job.ea;
      b1_ia_r  <= 8'd255 - job.ea;
      b1_ma_r  <= {8'd0, job.pix.dst_alpha} * {8'd0, 8'd255 - job.ea};
      for (int c = 0; c < 3; c++) begin
        b1_mc_r[c] <= {8'd0, dst_c[c]} * {8'd0, job.pix.dst_alpha};
        b1_sc_r[c] <= {8'd0, src_c[c]} * {8'd0, job.ea};
      end

      b2_pix_r <= b1_pix_r;
      b2_byp_r <= b1_byp_r;
      b2_ea_r  <= b1_ea_r;
      b2_xa_r  <= xa_nxt;
      b2_qa0_r <= d255_est(xa_nxt);
      for (int c = 0; c < 3; c++) begin
        b2_mc2_r[c] <= {8'd0, b1_mc_r[c]} * {16'd0, b1_ia_r};
        b2_sc_r[c]  <= b1_sc_r[c];
      end

      b3_pix_r  <= b2_pix_r;
      b3_byp_r  <= b2_byp_r;
      b3_ea_r   <= b2_ea_r;
      b3_term_r <= term_full[7:0];
      for (int c = 0; c < 3; c++) begin
        b3_xc_r[c]  <= xc_nxt[c];
        b3_qc0_r[c] <= d255_est(xc_nxt[c]);
        b3_sc_r[c]  <= b2_sc_r[c];
      end

      b4_pix_r <= b3_pix_r;
      b4_byp_r <= b3_byp_r;
      b4_oa_r  <= b3_ea_r + b3_term_r;
      for (int c = 0; c < 3; c++) begin
        b4_cp_r[c] <= {1'b0, b3_sc_r[c]} + {1'b0, qc_full[c]};
      end

      b5_pix_r <= b4_pix_r;
      b5_byp_r <= b4_byp_r;
      b5_oa_r  <= b4_oa_r;
      for (int c = 0; c < 3; c++) begin
        b5_dvd_r[c] <= b4_cp_r[c] + {10'd0, b4_oa_r[7:1]};
      end
    end
  end

  // Restoring divider, one quotient bit per stage for all three channels.
  logic             dv_r   [DVD_W];
  rob_side_t        side_r [DVD_W];
  logic [7:0]       rem_r  [DVD_W][3];
  logic [DVD_W-1:0] quo_r  [DVD_W][3];
  logic [DVD_W-1:0] dvd_r  [DVD_W][3];

  for (genvar s = 0; s < DVD_W; s++) begin : g_div
    logic             v_in;
    rob_side_t        side_in;
    logic [7:0]       rem_in [3];
    logic [DVD_W-1:0] quo_in [3];
    logic [DVD_W-1:0] dvd_in [3];

    if (s == 0) begin : g_first
      always_comb begin
        v_in           = b5_v_r;
        side_in.bypass = b5_byp_r;
        side_in.oa     = b5_oa_r;
        side_in.dr     = b5_pix_r.dst_red;
        side_in.dg     = b5_pix_r.dst_green;
        side_in.db     = b5_pix_r.dst_blue;
        side_in.da     = b5_pix_r.dst_alpha;
        for (int c = 0; c < 3; c++) begin
          rem_in[c] = '0;
          quo_in[c] = '0;
          dvd_in[c] = b5_dvd_r[c];
        end
      end
    end else begin : g_next
      always_comb begin
        v_in    = dv_r[s-1];
        side_in = side_r[s-1];
        for (int c = 0; c < 3; c++) begin
          rem_in[c] = rem_r[s-1][c];
          quo_in[c] = quo_r[s-1][c];
          dvd_in[c] = dvd_r[s-1][c];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[s] <= 1'b0;
      end else if (ben) begin
        dv_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ben) begin
        side_r[s] <= side_in;
      end
    end

    for (genvar c = 0; c < 3; c++) begin : g_ch
      logic [8:0] trial;
      logic       ge;
      assign trial = {rem_in[c], dvd_in[c][DVD_W-1-s]};
      assign ge    = (trial >= {1'b0, side_in.oa});

      always_ff @(posedge clk) begin
        if (ben) begin
          rem_r[s][c] <= ge ? 8'(trial - {1'b0, side_in.oa}) : trial[7:0];
          quo_r[s][c] <= {quo_in[c][DVD_W-2:0], ge};
          dvd_r[s][c] <= dvd_in[c];
        end
      end
    end
  end

  // Output register
  rob_out_t  out_data_r;
  rob_out_t  res_nxt;
  rob_side_t last;

  assign last = side_r[DVD_W-1];

  always_comb begin
    if (last.bypass) begin
      res_nxt.out_red   = last.dr;
      res_nxt.out_green = last.dg;
      res_nxt.out_blue  = last.db;
      res_nxt.out_alpha = last.da;
    end else if (last.oa == 8'd0) begin
      res_nxt = '0;
    end else begin
      res_nxt.out_red   = quo_r[DVD_W-1][0][7:0];
      res_nxt.out_green = quo_r[DVD_W-1][1][7:0];
      res_nxt.out_blue  = quo_r[DVD_W-1][2][7:0];
      res_nxt.out_alpha = last.oa;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ben) begin
      out_valid_r <= dv_r[DVD_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ROB_ASSERT_NXT(a_stall_freezes, !ben, $stable(b5_v_r) && $stable(out_valid_r), "back moved while stalled")
  `ROB_ASSERT_IMP(a_oa_nonzero, dv_r[DVD_W-1] && !last.bypass, last.oa != 8'd0, "zero divisor on a blended pixel")
  `ROB_ASSERT_IMP(a_rem_range, dv_r[DVD_W-1] && !last.bypass, rem_r[DVD_W-1][0] < last.oa, "divider remainder out of range")

endmodule

// ===== rtl/core/rgba_over_alpha_blender_unit.sv =====
// ----------------------------------------------------------------------------
// rgba_over_alpha_blender_unit
// Source-over compositing of one 8-bit RGBA pixel per beat, with layer
// opacity and gray mode registers.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | rob_in_t (source and canvas pixel)
//  out_    | output    | out_valid / out_ready | rob_out_t (composited pixel)
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pixel is taken every clock while in_ready is high. An accepted beat passes
// three front stages, the queue, five sum stages, the 17-stage divide by the
// output alpha and the output register before out_valid rises.
// Reset is synchronous and sets opacity to 255 and gray mode off; no clearing
// pass is needed. A stall on the output freezes the back pipeline, the queue
// then fills and the front stalls behind it. Configuration is always ready.
// ----------------------------------------------------------------------------
module rgba_over_alpha_blender_unit #(
  parameter int unsigned QUEUE_DEPTH = rob_pkg::ROB_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rob_pkg::rob_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rob_pkg::rob_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rob_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_data
);
  import rob_pkg::*;

  rob_cfg_t cfg_r;
  rob_job_t fj, qj;
  logic     fj_valid, fj_ready, qj_valid, qj_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.opacity <= 8'd255;
      cfg_r.gray    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LAYER_OPACITY: cfg_r.opacity <= cfg_data;
        REG_GRAY_MODE:     cfg_r.gray    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rob_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job       (fj)
  );

  rob_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .push_data  (fj),
    .pop_valid  (qj_valid),
    .pop_ready  (qj_ready),
    .pop_data   (qj)
  );

  rob_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qj_valid),
    .job_ready (qj_ready),
    .job       (qj),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/rgba_over_alpha_blender_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_over_alpha_blender_unit_tb
// Drives source and canvas pixels through the source-over blender under
// several opacity and gray settings, predicts each composited pixel and
// compares it field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module rgba_over_alpha_blender_unit_tb;
  import rob_pkg::*;

  // Expected composited pixels, held in order of acceptance.
  class blend_scoreboard;
    rob_out_t   pending[$];
    logic [7:0] opacity;
    logic       gray;
    int         mismatches;
    int         checked;

    function new();
      opacity    = 8'd255;
      gray       = 1'b0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function automatic int unsigned div255(input int unsigned v);
      return (v + 127) / 255;
    endfunction

    function void note_pixel(input rob_in_t p);
      int unsigned sc[3];
      int unsigned dc[3];
      int unsigned ea, ia, oa, cp;
      logic [7:0]  res[3];
      rob_out_t    e;
      sc[0] = p.src_red;
      sc[1] = gray ? p.src_red : p.src_green;
      sc[2] = gray ? p.src_red : p.src_blue;
      dc[0] = p.dst_red;
      dc[1] = p.dst_green;
      dc[2] = p.dst_blue;
      ea = div255(int'(p.src_alpha) * int'(opacity));
      if (ea == 0) begin
        e = '{p.dst_red, p.dst_green, p.dst_blue, p.dst_alpha};
      end else begin
        ia = 255 - ea;
        oa = ea + div255(int'(p.dst_alpha) * ia);
        if (oa == 0) begin
          e = '0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            cp = sc[i] * ea + div255(dc[i] * int'(p.dst_alpha) * ia);
            res[i] = 8'((cp + oa / 2) / oa);
          end
          e = '{res[0], res[1], res[2], 8'(oa)};
        end
      end
      pending.insert(pending.size(), e);
    endfunction

    task check_pixel(input rob_out_t got);
      rob_out_t e;
      if (pending.size() == 0) begin
        report("unexpected pixel", got, got);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.out_red !== e.out_red) report("red", got, e);
      if (got.out_green !== e.out_green) report("green", got, e);
      if (got.out_blue !== e.out_blue) report("blue", got, e);
      if (got.out_alpha !== e.out_alpha) report("alpha", got, e);
    endtask

    task report(input string what, input rob_out_t got, input rob_out_t e);
      mismatches++;
      $display("mismatch %s at %0t: got %h expected %h", what, $realtime, got, e);
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  rob_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rob_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  blend_scoreboard sb = new();
  int  send_idle_pct = 27;
  int  recv_idle_pct = 70;
  bit  hold_output = 1'b0;
  int  sent = 0;

  always #5 clk = ~clk;

  rgba_over_alpha_blender_unit u_dut (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_pixel(out_data);
  end

  // Receiver: random back-pressure, or a long hold when asked.
  always @(negedge clk) begin
    out_ready <= !hold_output && ($urandom_range(99) >= recv_idle_pct);
  end

  // Drivers assign at the falling edge, well clear of the sampling edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_LAYER_OPACITY) sb.opacity = val;
    else if (idx == REG_GRAY_MODE) sb.gray = val[0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_pixel(input rob_in_t p);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    in_data  = p;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(p);
    sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic rob_in_t rand_pixel();
    rob_in_t p;
    p = rob_in_t'({$urandom, $urandom});
    // Bias alpha towards the edges where the rounding is most delicate.
    case ($urandom_range(5))
      0: p.src_alpha = 8'd0;
      1: p.src_alpha = 8'd255;
      2: p.dst_alpha = 8'd0;
      3: p.dst_alpha = 8'd255;
      default: ;
    endcase
    return p;
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) send_pixel(rand_pixel());
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes of alpha, colour and opacity.
    send_pixel('0);
    send_pixel('1);
    send_pixel('{8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd255, 8'd1, 8'd0});
    send_pixel('{8'd10, 8'd20, 8'd30, 8'd0, 8'd40, 8'd50, 8'd60, 8'd70});
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0, 8'd255});
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd128, 8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel('{8'd200, 8'd100, 8'd50, 8'd127, 8'd7, 8'd8, 8'd9, 8'd0});
    drain();
    write_reg(REG_LAYER_OPACITY, 8'd0);
    send_pixel('{8'd1, 8'd2, 8'd3, 8'd255, 8'd4, 8'd5, 8'd6, 8'd7});
    send_pixel('1);
    drain();
    write_reg(REG_LAYER_OPACITY, 8'd1);
    write_reg(REG_GRAY_MODE, 8'd1);
    send_pixel('{8'd99, 8'd0, 8'd255, 8'd255, 8'd1, 8'd2, 8'd3, 8'd4});
    send_pixel('{8'd255, 8'd1, 8'd2, 8'd128, 8'd10, 8'd20, 8'd30, 8'd255});
    drain();
    write_reg(REG_LAYER_OPACITY, 8'd255);
    send_pixel('{8'd99, 8'd0, 8'd255, 8'd255, 8'd1, 8'd2, 8'd3, 8'd4});
    send_pixel('{8'd37, 8'd1, 8'd2, 8'd64, 8'd200, 8'd20, 8'd30, 8'd200});
    drain();
    // An out-of-range index must leave both registers alone.
    write_reg(4'd15, 8'd0);
    send_pixel('{8'd50, 8'd60, 8'd70, 8'd200, 8'd1, 8'd2, 8'd3, 8'd100});
    drain();

    write_reg(REG_GRAY_MODE, 8'd0);
    random_phase(100);
    drain();
    send_idle_pct = 70;
    recv_idle_pct = 27;
    write_reg(REG_LAYER_OPACITY, 8'($urandom_range(2, 254)));
    write_reg(REG_GRAY_MODE, 8'd1);
    random_phase(100);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_LAYER_OPACITY, 8'd128);
    write_reg(REG_GRAY_MODE, 8'd0);
    // Hold the output for a long stretch so that the pipeline backs up.
    fork
      begin
        hold_output = 1'b1;
        repeat (200) @(negedge clk);
        hold_output = 1'b0;
      end
      random_phase(60);
    join
    drain();
    write_reg(REG_LAYER_OPACITY, 8'd255);
    random_phase(80);
    drain();
    write_reg(REG_LAYER_OPACITY, 8'($urandom));
    write_reg(REG_GRAY_MODE, 8'($urandom));
    random_phase(60);
    drain();

    $display("Covered %0d pixels, %0d results checked, over opacity extremes,",
             sent, sb.checked);
    $display("gray mode on and off, bypass on zero alpha and long output stalls.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rob_pkg.sv
rtl/core/rob_front.sv
rtl/core/rob_queue.sv
rtl/core/rob_back.sv
rtl/core/rgba_over_alpha_blender_unit.sv
tb/rgba_over_alpha_blender_unit_tb.sv
